>>> design/mip_pkg.sv
// Package for the minimum-insertion palindrome block.
// Holds the word types of both channels and the controller/datapath command and status structs.
// No dependencies.
package mip_pkg;

    localparam int LETTER_W = 8;
    localparam int COST_W   = 5;

    // One input word: a letter and its end-of-word mark.
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                end_of_word;
    } t_in_word;

    // One output word: a palindrome letter with the insertion count and flags.
    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic [COST_W-1:0]   insertions;
        logic                final_letter;
        logic                too_long;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic fill_init;
        logic fill_b;
        logic fill_c;
        logic walk_init;
        logic walk;
        logic walk_step;
        logic pop_out;
        logic ovf_out;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic ovf_next;
        logic len_one;
        logic fill_last;
        logic walk_done;
        logic walk_final;
        logic pop_final;
    } t_stat;

endpackage

>>> design/min_insertion_palindrome.sv
// Input: a letter without end mark is taken at once; the input stalls from the end
// mark until the last palindrome word is loaded into the output register.
// After the end mark the block runs a fill setup, fills the cost of every span of two or
// more letters, sets up the rebuild walk and emits the words of the walk and then the
// mirrored letters, each when the output register is free. A too-long word is registered
// once the output register is free. Synchronous active-low reset clears control state.
module min_insertion_palindrome #(
    parameter int MAX_LEN = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mip_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mip_pkg::t_out_word  o_out
);

    mip_pkg::t_cmd  cmd;
    mip_pkg::t_stat stat;

    // Sequencer.
    mip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.end_of_word),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Storage and arithmetic.
    mip_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> design/mip_dp.sv
// Datapath of the minimum-insertion palindrome block: letter store, span cost
// memory, mirror stack, index counters and the output register. Uses mip_pkg.
module mip_dp #(
    parameter int MAX_LEN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mip_pkg::t_cmd     i_cmd,
    output mip_pkg::t_stat    o_stat,
    input  mip_pkg::t_in_word i_in,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output mip_pkg::t_out_word o_out
);

    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int CDEPTH = 1 << (2 * AW);
    localparam int CW     = mip_pkg::COST_W;
    localparam int BW     = mip_pkg::LETTER_W;

    // Memories.
    logic [BW-1:0] r_word_mem  [MAX_LEN];
    logic [CW-1:0] r_cost_mem  [CDEPTH];
    logic [BW-1:0] r_stack_mem [MAX_LEN];

    // Registered read data.
    logic [BW-1:0] r_w0, r_w1, r_sd;
    logic [CW-1:0] r_c0, r_c1;

    // Control and working registers.
    logic [LW-1:0] r_len, r_span, r_depth;
    logic          r_ovf;
    logic [AW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_cost, r_ca, r_cb;
    logic          r_out_valid;
    mip_pkg::t_out_word r_out;

    logic [AW-1:0]   hi_m1, lo_p1;
    logic [2*AW-1:0] c0_addr, c1_addr;
    logic [LW-1:0]   depth_m1;
    logic [AW-1:0]   stack_rd_addr;
    logic            len_full, hi_is_end, out_free;
    logic [CW-1:0]   inner, minv, fill_val, cjm1;
    logic            match, eq, gap1, right_pick, done;
    logic [LW-1:0]   depth_nx;
    logic [BW-1:0]   front, push_val;

    // Address formation.
    always_comb begin
        hi_m1         = r_hi - 1'b1;
        lo_p1         = r_lo + 1'b1;
        c0_addr       = i_cmd.fill_b ? {lo_p1, hi_m1} : {r_lo, hi_m1};
        c1_addr       = i_cmd.walk ? {r_lo, r_hi} : {lo_p1, r_hi};
        depth_m1      = LW'(r_depth - 1'b1);
        stack_rd_addr = depth_m1[AW-1:0];
    end

    // Span fill arithmetic.
    always_comb begin
        len_full  = (r_len == LW'(MAX_LEN));
        hi_is_end = (LW'(r_hi) == LW'(r_len - 1'b1));
        match     = (r_w0 == r_w1);
        inner     = (r_span <= LW'(3)) ? '0 : r_c0;
        minv      = (r_ca < r_cb) ? r_ca : r_cb;
        fill_val  = match ? inner : CW'(minv + 1'b1);
    end

    // Rebuild step decision.
    always_comb begin
        eq         = (r_lo == r_hi);
        gap1       = (AW'(r_hi - r_lo) == AW'(1));
        cjm1       = (hi_m1 == r_lo) ? '0 : r_c0;
        right_pick = ({1'b0, r_c1} == ({1'b0, cjm1} + (CW+1)'(1)));
        done       = eq || (match && gap1);
        depth_nx   = eq ? r_depth : LW'(r_depth + 1'b1);
        if (eq || match) begin
            front    = r_w0;
            push_val = r_w1;
        end else if (right_pick) begin
            front    = r_w1;
            push_val = r_w1;
        end else begin
            front    = r_w0;
            push_val = r_w0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller.
    always_comb begin
        o_stat.out_free   = out_free;
        o_stat.ovf_next   = r_ovf || len_full;
        o_stat.len_one    = (r_len == LW'(1));
        o_stat.fill_last  = hi_is_end && (r_span == r_len);
        o_stat.walk_done  = done;
        o_stat.walk_final = done && (depth_nx == '0);
        o_stat.pop_final  = (r_depth == LW'(1));
    end

    // Letter store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !len_full) begin
            r_word_mem[r_len[AW-1:0]] <= i_in.letter;
        end
        r_w0 <= r_word_mem[r_lo];
        r_w1 <= r_word_mem[r_hi];
    end

    // Span cost memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_c) begin
            r_cost_mem[{r_lo, r_hi}] <= fill_val;
        end
        r_c0 <= r_cost_mem[c0_addr];
        r_c1 <= r_cost_mem[c1_addr];
    end

    // Mirror stack: push on each rebuild step that pairs letters, registered pop read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && !eq) begin
            r_stack_mem[r_depth[AW-1:0]] <= push_val;
        end
        r_sd <= r_stack_mem[stack_rd_addr];
    end

    // Payload working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_b) begin
            r_ca <= (r_span == LW'(2)) ? '0 : r_c0;
            r_cb <= (r_span == LW'(2)) ? '0 : r_c1;
        end
        if (i_cmd.walk_step) begin
            r_out.out_letter   <= front;
            r_out.insertions   <= r_cost;
            r_out.final_letter <= done && (depth_nx == '0);
            r_out.too_long     <= 1'b0;
        end else if (i_cmd.pop_out) begin
            r_out.out_letter   <= r_sd;
            r_out.insertions   <= r_cost;
            r_out.final_letter <= (r_depth == LW'(1));
            r_out.too_long     <= 1'b0;
        end else if (i_cmd.ovf_out) begin
            r_out.out_letter   <= '0;
            r_out.insertions   <= '0;
            r_out.final_letter <= 1'b1;
            r_out.too_long     <= 1'b1;
        end
    end

    // Counters, indices and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_span      <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_depth     <= '0;
            r_cost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.walk_step || i_cmd.pop_out || i_cmd.ovf_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.store) begin
                if (!len_full) begin
                    r_len <= LW'(r_len + 1'b1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.fill_init) begin
                r_span <= LW'(2);
                r_lo   <= '0;
                r_hi   <= AW'(1);
                r_cost <= '0;
            end

            if (i_cmd.fill_c) begin
                r_cost <= fill_val;
                if (hi_is_end) begin
                    r_span <= LW'(r_span + 1'b1);
                    r_lo   <= '0;
                    r_hi   <= AW'(r_span);
                end else begin
                    r_lo <= lo_p1;
                    r_hi <= AW'(r_hi + 1'b1);
                end
            end

            if (i_cmd.walk_init) begin
                r_lo    <= '0;
                r_hi    <= AW'(r_len - 1'b1);
                r_depth <= '0;
            end

            if (i_cmd.walk_step) begin
                r_depth <= depth_nx;
                if (!eq) begin
                    if (match) begin
                        r_lo <= lo_p1;
                        r_hi <= hi_m1;
                    end else if (right_pick) begin
                        r_hi <= hi_m1;
                    end else begin
                        r_lo <= lo_p1;
                    end
                end
            end

            if (i_cmd.pop_out) begin
                r_depth <= LW'(r_depth - 1'b1);
            end

            if (i_cmd.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
                r_lo  <= '0;
                r_hi  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> design/mip_ctrl.sv
// Controller of the minimum-insertion palindrome block: sequences letter
// collection, span fill, rebuild walk and mirror pop. Uses mip_pkg.
module mip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  mip_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output mip_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_COLLECT,
        S_OVF,
        S_FILL_INIT,
        S_FILL_A,
        S_FILL_B,
        S_FILL_C,
        S_WALK_INIT,
        S_WALK_RD,
        S_WALK_STEP,
        S_POP_RD,
        S_POP_OUT
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_COLLECT: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) begin
                        n_state = i_stat.ovf_next ? S_OVF : S_FILL_INIT;
                    end
                end
            end
            S_OVF: begin
                if (i_stat.out_free) begin
                    o_cmd.ovf_out = 1'b1;
                    o_cmd.clear   = 1'b1;
                    n_state       = S_COLLECT;
                end
            end
            S_FILL_INIT: begin
                o_cmd.fill_init = 1'b1;
                n_state = i_stat.len_one ? S_WALK_INIT : S_FILL_A;
            end
            S_FILL_A: begin
                n_state = S_FILL_B;
            end
            S_FILL_B: begin
                o_cmd.fill_b = 1'b1;
                n_state      = S_FILL_C;
            end
            S_FILL_C: begin
                o_cmd.fill_c = 1'b1;
                n_state = i_stat.fill_last ? S_WALK_INIT : S_FILL_A;
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd.walk = 1'b1;
                n_state    = S_WALK_STEP;
            end
            S_WALK_STEP: begin
                o_cmd.walk = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_stat.walk_final) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_COLLECT;
                    end else if (i_stat.walk_done) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_out = 1'b1;
                    if (i_stat.pop_final) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_COLLECT;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/mip_chk.sv
// Port checker for the minimum-insertion palindrome block, bound to the top level.
// Uses mip_pkg for the output word type.
module mip_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mip_pkg::t_out_word o_out
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output word changed");

    // A too-long word is always the last word of its result.
    a_ovf_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.too_long |-> o_out.final_letter)
        else $error("too-long word not marked final");

    // A too-long word carries no letter and no count.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.too_long |-> o_out.out_letter == '0 && o_out.insertions == '0)
        else $error("too-long word carries data");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind min_insertion_palindrome mip_chk u_mip_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> tb/min_insertion_palindrome_test.sv
// Testbench for min_insertion_palindrome: drives words letter by letter and checks the
// palindrome words against a behavioral predictor held in a small scoreboard class.
// Depends on mip_pkg and the min_insertion_palindrome RTL.
`timescale 1ns / 1ps

module min_insertion_palindrome_test;

    localparam int MAX_LEN   = 32;
    localparam int CYCLE_CAP = 1000000;

    // Predicts the palindrome words of each finished input word and checks the outputs.
    class palindrome_board;
        logic [7:0] letters[MAX_LEN];
        int unsigned n_letters;
        bit overflow;
        mip_pkg::t_out_word pending[$];
        int unsigned errors;

        function new();
            n_letters = 0;
            overflow  = 0;
            errors    = 0;
        endfunction

        // Builds the expected words for the stored word.
        function void build_palindrome();
            logic [4:0] costs[MAX_LEN][MAX_LEN];
            logic [7:0] mirror[$];
            logic [7:0] front;
            logic [4:0] total;
            int lo, hi, i, j, len;
            bit stop;
            mip_pkg::t_out_word w;
            for (i = 0; i < n_letters; i++)
                for (j = 0; j < MAX_LEN; j++) costs[i][j] = 0;
            for (len = 2; len <= n_letters; len++)
                for (i = 0; i + len <= n_letters; i++) begin
                    j = i + len - 1;
                    if (letters[i] == letters[j])
                        costs[i][j] = (i + 1 <= j - 1) ? costs[i+1][j-1] : 5'd0;
                    else
                        costs[i][j] = ((costs[i][j-1] < costs[i+1][j]) ?
                                       costs[i][j-1] : costs[i+1][j]) + 5'd1;
                end
            total = costs[0][n_letters-1];
            lo = 0;
            hi = n_letters - 1;
            stop = 0;
            while (!stop && lo <= hi) begin
                if (lo == hi) begin
                    front = letters[lo];
                    stop = 1;
                end else if (letters[lo] == letters[hi]) begin
                    front = letters[lo];
                    mirror = {mirror, letters[hi]};
                    if (hi - lo == 1) stop = 1;
                    else begin
                        lo++;
                        hi--;
                    end
                end else if (costs[lo][hi] == costs[lo][hi-1] + 5'd1) begin
                    // Ties insert the right letter.
                    front = letters[hi];
                    mirror = {mirror, letters[hi]};
                    hi--;
                end else begin
                    front = letters[lo];
                    mirror = {mirror, letters[lo]};
                    lo++;
                end
                w = '{out_letter: front, insertions: total, final_letter: 1'b0,
                      too_long: 1'b0};
                pending = {pending, w};
            end
            while (mirror.size() > 0) begin
                w = '{out_letter: mirror.pop_back(), insertions: total,
                      final_letter: 1'b0, too_long: 1'b0};
                pending = {pending, w};
            end
            pending[pending.size()-1].final_letter = 1'b1;
        endfunction

        // Notes one accepted input word.
        function void note_letter(mip_pkg::t_in_word in_w);
            mip_pkg::t_out_word w;
            if (n_letters < MAX_LEN) begin
                letters[n_letters] = in_w.letter;
                n_letters++;
            end else begin
                overflow = 1;
            end
            if (!in_w.end_of_word) return;
            if (overflow) begin
                w = '{out_letter: 8'd0, insertions: 5'd0, final_letter: 1'b1,
                      too_long: 1'b1};
                pending = {pending, w};
            end else begin
                build_palindrome();
            end
            n_letters = 0;
            overflow  = 0;
        endfunction

        // Checks one accepted output word against the oldest expectation.
        function void check_word(mip_pkg::t_out_word got);
            mip_pkg::t_out_word want;
            if (pending.size() == 0) begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_letter !== want.out_letter) begin
                $error("out_letter: expected %h, got %h", want.out_letter, got.out_letter);
                errors++;
            end
            if (got.insertions !== want.insertions) begin
                $error("insertions: expected %0d, got %0d", want.insertions, got.insertions);
                errors++;
            end
            if (got.final_letter !== want.final_letter) begin
                $error("final_letter: expected %b, got %b",
                       want.final_letter, got.final_letter);
                errors++;
            end
            if (got.too_long !== want.too_long) begin
                $error("too_long: expected %b, got %b", want.too_long, got.too_long);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    mip_pkg::t_in_word  i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    mip_pkg::t_out_word o_out;

    palindrome_board board;
    int unsigned cycle_count;
    int unsigned words_sent;
    bit          hold_output;

    min_insertion_palindrome #(.MAX_LEN(MAX_LEN)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one input word and waits until the block takes it. Valid stays high
    // into the next call, which drops it only when a gap follows.
    task automatic send_letter(input logic [7:0] letter, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in.letter      <= letter;
        i_in.end_of_word <= last;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Sends a whole word of the given length.
    task automatic send_word(input int len, input int alphabet);
        int k;
        for (k = 0; k < len; k++)
            send_letter(alphabet == 0 ? 8'($urandom) : 8'($urandom_range(97, 97 + alphabet - 1)),
                        k == len - 1);
    endtask

    // Sends a word made from a fixed pattern.
    task automatic send_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++)
            send_letter(text[k], k == text.len() - 1);
    endtask

    // Accepted words on both channels go to the scoreboard at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_letter(i_in);
            if (o_out_valid && !i_out_stall) board.check_word(o_out);
        end
    end

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge i_clk) begin
        if (hold_output) i_out_stall <= 1'b1;
        else if (cycle_count % 600 < 150) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < 30);
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("min_insertion_palindrome regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps going.
    initial begin
        int held;
        held = 0;
        wait (words_sent >= 40);
        @(negedge i_clk);
        hold_output = 1'b1;
        while (held < 400) begin
            @(negedge i_clk);
            held++;
        end
        hold_output = 1'b0;
    end

    // Stimulus.
    initial begin
        int k;
        int len;
        int r;
        int extra;
        board        = new();
        cycle_count  = 0;
        words_sent   = 0;
        hold_output  = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: single letter, extremes, matches, ties, overflow.
        send_letter(8'h00, 1'b1);
        send_letter(8'hFF, 1'b1);
        send_text("ab");
        send_text("aa");
        send_text("abc");
        send_text("racecar");
        send_letter(8'h00, 1'b0);
        send_letter(8'hFF, 1'b1);
        for (k = 0; k < MAX_LEN; k++) send_letter(8'(k * 8 + 1), k == MAX_LEN - 1);
        for (k = 0; k < MAX_LEN + 2; k++) send_letter(8'($urandom), k == MAX_LEN + 1);

        // Random words: mostly short, few full or overlong.
        while (words_sent < 330) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 8);
            else if (r < 94) len = $urandom_range(9, 20);
            else if (r < 97) len = MAX_LEN;
            else len = MAX_LEN + $urandom_range(1, 3);
            send_word(len, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4));
        end
        i_in_valid <= 1'b0;

        extra = 0;
        while (board.pending.size() > 0) @(negedge i_clk);
        while (extra < 50) begin
            @(negedge i_clk);
            extra++;
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("min_insertion_palindrome regression: pass");
        else
            $display("min_insertion_palindrome regression: fail");
        $finish;
    end

endmodule
